// ----- design/rlh_pkg.sv -----
// package for the region luma histogram unit
// holds field widths, operation and register codes, controller types
// no dependencies

package rlh_pkg;

  localparam int OP_W       = 2;
  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int LUMA_W     = 8;
  localparam int BIN_W      = 8;
  localparam int NUM_BINS   = 256;
  localparam int COUNT_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_ALT    = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ready;
    logic read_en;
    logic clear;
    logic write_en;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            item_valid;
    logic [OP_W-1:0] item_op;
    logic            item_hit;
    logic            out_free;
  } sts_t;

endpackage

// ----- design/rlh_if.sv -----
// channel interfaces for the region luma histogram unit
// depends on rlh_pkg for field widths

interface rlh_item_if
  import rlh_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [LUMA_W-1:0]  luma;
  logic [BIN_W-1:0]   bin_index;

  modport source (output valid, operation, column, row, luma, bin_index, input ready);
  modport sink (input valid, operation, column, row, luma, bin_index, output ready);
endinterface

interface rlh_result_if
  import rlh_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic [COUNT_W-1:0] region_pixels;

  modport source (output valid, bin_count, region_pixels, input ready);
  modport sink (input valid, bin_count, region_pixels, output ready);
endinterface

// ----- design/rlh_ctrl.sv -----
// controller state machine for the region luma histogram unit
// depends on rlh_pkg; drives commands to rlh_datapath from its status

module rlh_ctrl
  import rlh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   cur_read;
  logic   cur_read_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_read <= 1'b0;
    end else begin
      state    <= state_next;
      cur_read <= cur_read_next;
    end
  end

  always_comb begin
    state_next    = state;
    cur_read_next = cur_read;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.item_valid) begin
          case (op_t'(sts.item_op))
            OP_CLEAR: cmd.clear = 1'b1;
            OP_PIXEL: begin
              // pixels outside the region finish here
              if (sts.item_hit) begin
                cmd.read_en   = 1'b1;
                cur_read_next = 1'b0;
                state_next    = ST_LOOKUP;
              end
            end
            OP_READ: begin
              cmd.read_en   = 1'b1;
              cur_read_next = 1'b1;
              state_next    = ST_LOOKUP;
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (!cur_read) begin
          cmd.write_en = 1'b1;
          state_next   = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/rlh_datapath.sv -----
// datapath for the region luma histogram unit: config registers, region test,
// bin memory with valid bits, region size product and result register
// depends on rlh_pkg and rlh_if; controlled by rlh_ctrl

module rlh_datapath
  import rlh_pkg::*;
#(
  parameter int FRAME_MAX_WIDTH  = 4096,
  parameter int FRAME_MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rlh_item_if.sink              item,
  rlh_result_if.source          result,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [COORD_W-1:0] region_left;
  logic [COORD_W-1:0] region_top;
  logic [SIZE_W-1:0]  region_width;
  logic [SIZE_W-1:0]  region_height;
  logic               alternate_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_left    <= '0;
      region_top     <= '0;
      region_width   <= '0;
      region_height  <= '0;
      alternate_rows <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LEFT:   region_left    <= cfg_data[COORD_W-1:0];
        REG_TOP:    region_top     <= cfg_data[COORD_W-1:0];
        REG_WIDTH:  region_width   <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: region_height  <= cfg_data[SIZE_W-1:0];
        REG_ALT:    alternate_rows <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // region size, registered from the config registers
  logic [SIZE_W-1:0]     counted_rows;
  logic [2*SIZE_W-1:0]   size_product;
  logic [COUNT_W-1:0]    region_size;

  always_comb begin
    // one extra bit so the round-up carry of the largest height survives
    counted_rows = alternate_rows
                 ? SIZE_W'(({1'b0, region_height} + (SIZE_W+1)'(1)) >> 1)
                 : region_height;
    size_product = {{SIZE_W{1'b0}}, region_width} * {{SIZE_W{1'b0}}, counted_rows};
  end

  always_ff @(posedge clk) begin
    region_size <= (|size_product[2*SIZE_W-1:COUNT_W]) ? COUNT_MAX
                                                       : size_product[COUNT_W-1:0];
  end

  // region test on the offered pixel
  logic [COORD_W+1:0] col_end;
  logic [COORD_W+1:0] row_end;
  logic               in_frame;
  logic               in_cols;
  logic               in_rows;
  logic               row_phase_ok;

  always_comb begin
    col_end  = {2'b00, region_left} + {1'b0, region_width};
    row_end  = {2'b00, region_top} + {1'b0, region_height};
    in_frame = (32'(item.column) < 32'(FRAME_MAX_WIDTH)) &&
               (32'(item.row) < 32'(FRAME_MAX_HEIGHT));
    in_cols  = (item.column >= region_left) && ({2'b00, item.column} < col_end);
    in_rows  = (item.row >= region_top) && ({2'b00, item.row} < row_end);
    row_phase_ok = !alternate_rows || !(item.row[0] ^ region_top[0]);
  end

  // bin memory; entries with a clear valid bit read as zero
  logic [COUNT_W-1:0]  bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_valid;
  logic [BIN_W-1:0]    rd_addr;
  logic [BIN_W-1:0]    addr_q;
  logic [COUNT_W-1:0]  rd_data;
  logic                rd_valid;
  logic [COUNT_W-1:0]  cur_count;
  logic [COUNT_W-1:0]  inc_count;

  assign rd_addr = (op_t'(item.operation) == OP_PIXEL) ? item.luma : item.bin_index;

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_data <= bin_mem[rd_addr];
      addr_q  <= rd_addr;
    end
    if (cmd.write_en) begin
      bin_mem[addr_q] <= inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        bin_valid <= '0;
      end else if (cmd.write_en) begin
        bin_valid[addr_q] <= 1'b1;
      end
      if (cmd.read_en) begin
        rd_valid <= bin_valid[rd_addr];
      end
    end
  end

  always_comb begin
    cur_count = rd_valid ? rd_data : '0;
    inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
  end

  // result register
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic [COUNT_W-1:0] out_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count  <= cur_count;
      out_pixels <= region_size;
    end
  end

  assign result.valid         = out_valid;
  assign result.bin_count     = out_count;
  assign result.region_pixels = out_pixels;
  assign item.ready           = cmd.ready;

  always_comb begin
    sts.item_valid = item.valid;
    sts.item_op    = item.operation;
    sts.item_hit   = in_frame && in_cols && in_rows && row_phase_ok;
    sts.out_free   = !out_valid || result.ready;
  end

endmodule

// ----- design/region_luma_histogram_unit.sv -----
// top level of the region luma histogram unit
// depends on rlh_pkg, rlh_if, rlh_ctrl and rlh_datapath
//
//   channel   direction  transaction content
//   item      in         operation, column, row, luma, bin_index
//   result    out        bin_count, region_pixels (read operations only)
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// clear, unused codes and pixels outside the region finish in the idle state
// counted pixels and reads read the bin memory in the idle state, then in
// the lookup state write back the saturated count or load the result register
// a read waits in the lookup state while the result register is still full
// synchronous reset zeroes config, bin valid bits and result valid at once

module region_luma_histogram_unit
  import rlh_pkg::*;
#(
  parameter int FRAME_MAX_WIDTH  = 4096,
  parameter int FRAME_MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rlh_item_if.sink              item,
  rlh_result_if.source          result
);

  cmd_t cmd;
  sts_t sts;

  rlh_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rlh_datapath #(
    .FRAME_MAX_WIDTH  (FRAME_MAX_WIDTH),
    .FRAME_MAX_HEIGHT (FRAME_MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
